[rtl/bsc_pkg.sv]
`default_nettype none

package bsc_pkg;

  // multiplier operands are 25-bit two's complement values
  localparam int unsigned MUL_BITS = 25;
  localparam int unsigned CNT_W    = $clog2(MUL_BITS);

  typedef enum logic [1:0] {
    CFG_TEMP = 2'd0,
    CFG_SENS = 2'd1,
    CFG_OFFS = 2'd2,
    CFG_QUAD = 2'd3
  } bsc_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_T3LD,
    ST_TMUL1,
    ST_TMUL2,
    ST_TFIN,
    ST_P11LD,
    ST_P10LD,
    ST_P9MAC,
    ST_A2ACC,
    ST_P4LD,
    ST_P3MAC,
    ST_P2MAC,
    ST_P1MAC,
    ST_A1ACC,
    ST_P8LD,
    ST_P7MAC,
    ST_P6MAC,
    ST_P5MAC,
    ST_A0ACC,
    ST_OUT
  } bsc_state_e;

  typedef enum logic [1:0] {
    MSEL_D,
    MSEL_L,
    MSEL_P
  } bsc_msel_e;

  typedef enum logic [3:0] {
    AD_ZERO,
    AD_T3,
    AD_T2,
    AD_P11,
    AD_P10,
    AD_P9,
    AD_P4,
    AD_P3,
    AD_P2,
    AD_P1,
    AD_P8,
    AD_P7,
    AD_P6,
    AD_P5,
    AD_W
  } bsc_asel_e;

  typedef struct packed {
    logic      in_rdy;
    logic      mac_start;
    logic      load;
    logic      write;
    logic      src_s;
    logic      dst_s;
    bsc_msel_e msel;
    bsc_asel_e asel;
    logic      fin_t;
    logic      out_ld;
  } bsc_ctrl_t;

endpackage

`default_nettype wire

[rtl/bsc_mac.sv]
`default_nettype none

module bsc_mac #(
  parameter int unsigned AccW = 184
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [AccW-1:0]                  mcand_i,
  input  wire logic [AccW-1:0]                  addend_i,
  input  wire logic [bsc_pkg::MUL_BITS-1:0]     mplier_i,
  output logic                                  done_o,
  output logic [AccW-1:0]                       prod_o
);
  import bsc_pkg::*;

  logic [AccW-1:0]     prod_q, mcand_q, addv, sum;
  logic [MUL_BITS-1:0] mpl_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                run_q, done_q, last, sub;

  assign last = (cnt_q == CNT_W'(MUL_BITS - 1));
  // top multiplier bit carries negative weight
  assign sub  = last;

  always_comb begin
    if (mpl_q[0]) begin
      addv = sub ? ~mcand_q : mcand_q;
    end else begin
      addv = '0;
    end
    sum = prod_q + addv + AccW'(mpl_q[0] & sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q & last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q  <= addend_i;
      mcand_q <= mcand_i;
      mpl_q   <= mplier_i;
    end else if (run_q) begin
      prod_q  <= sum;
      mcand_q <= mcand_q << 1;
      mpl_q   <= mpl_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

[rtl/bsc_seq.sv]
`default_nettype none

module bsc_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  input  wire logic          tv_i,
  input  wire logic          pv_i,
  input  wire logic          mac_done_i,
  input  wire logic          out_free_i,
  output bsc_pkg::bsc_ctrl_t ctrl_o
);
  import bsc_pkg::*;

  bsc_state_e state_q, state_d;
  logic       issued_q, issued_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire_i) state_d = ST_DISP;
      ST_DISP: begin
        if (tv_i) state_d = ST_T3LD;
        else if (pv_i) state_d = ST_P11LD;
        else state_d = ST_OUT;
      end
      ST_T3LD:  state_d = ST_TMUL1;
      ST_TFIN:  state_d = pv_i ? ST_P11LD : ST_OUT;
      ST_P11LD: state_d = ST_P10LD;
      ST_P10LD: state_d = ST_P9MAC;
      ST_P4LD:  state_d = ST_P3MAC;
      ST_P8LD:  state_d = ST_P7MAC;
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      ST_TMUL1, ST_TMUL2, ST_P9MAC, ST_A2ACC, ST_P3MAC, ST_P2MAC, ST_P1MAC,
      ST_A1ACC, ST_P7MAC, ST_P6MAC, ST_P5MAC, ST_A0ACC: begin
        issued_d = 1'b1;
        if (mac_done_i) begin
          issued_d = 1'b0;
          unique case (state_q)
            ST_TMUL1: state_d = ST_TMUL2;
            ST_TMUL2: state_d = ST_TFIN;
            ST_P9MAC: state_d = ST_A2ACC;
            ST_A2ACC: state_d = ST_P4LD;
            ST_P3MAC: state_d = ST_P2MAC;
            ST_P2MAC: state_d = ST_P1MAC;
            ST_P1MAC: state_d = ST_A1ACC;
            ST_A1ACC: state_d = ST_P8LD;
            ST_P7MAC: state_d = ST_P6MAC;
            ST_P6MAC: state_d = ST_P5MAC;
            ST_P5MAC: state_d = ST_A0ACC;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '{in_rdy: 1'b0, mac_start: 1'b0, load: 1'b0, write: 1'b0,
               src_s: 1'b0, dst_s: 1'b0, msel: MSEL_L, asel: AD_ZERO,
               fin_t: 1'b0, out_ld: 1'b0};
    unique case (state_q)
      ST_TMUL1, ST_TMUL2, ST_P9MAC, ST_A2ACC, ST_P3MAC, ST_P2MAC, ST_P1MAC,
      ST_A1ACC, ST_P7MAC, ST_P6MAC, ST_P5MAC, ST_A0ACC: begin
        ctrl_o.mac_start = !issued_q;
        ctrl_o.write     = mac_done_i;
      end
      default: ;
    endcase
    unique case (state_q)
      ST_IDLE:  ctrl_o.in_rdy = 1'b1;
      ST_T3LD: begin
        ctrl_o.load = 1'b1;
        ctrl_o.asel = AD_T3;
      end
      ST_TMUL1: begin
        ctrl_o.msel = MSEL_D;
        ctrl_o.asel = AD_T2;
      end
      ST_TMUL2: ctrl_o.msel = MSEL_D;
      ST_TFIN:  ctrl_o.fin_t = 1'b1;
      ST_P11LD: begin
        ctrl_o.load  = 1'b1;
        ctrl_o.dst_s = 1'b1;
        ctrl_o.asel  = AD_P11;
      end
      ST_P10LD: begin
        ctrl_o.load = 1'b1;
        ctrl_o.asel = AD_P10;
      end
      ST_P9MAC: ctrl_o.asel = AD_P9;
      ST_P4LD: begin
        ctrl_o.load = 1'b1;
        ctrl_o.asel = AD_P4;
      end
      ST_P3MAC: ctrl_o.asel = AD_P3;
      ST_P2MAC: ctrl_o.asel = AD_P2;
      ST_P1MAC: ctrl_o.asel = AD_P1;
      ST_P8LD: begin
        ctrl_o.load = 1'b1;
        ctrl_o.asel = AD_P8;
      end
      ST_P7MAC: ctrl_o.asel = AD_P7;
      ST_P6MAC: ctrl_o.asel = AD_P6;
      ST_P5MAC: ctrl_o.asel = AD_P5;
      ST_A2ACC, ST_A1ACC, ST_A0ACC: begin
        ctrl_o.msel  = MSEL_P;
        ctrl_o.asel  = AD_W;
        ctrl_o.src_s = 1'b1;
        ctrl_o.dst_s = 1'b1;
      end
      ST_OUT:   ctrl_o.out_ld = out_free_i;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/barometric_sensor_compensation.sv]
`default_nettype none

// Barometric temperature and pressure compensation. All arithmetic runs on one
// bit-serial multiply-accumulate unit (one wide add per cycle): an item with
// both temperature and pressure takes two multiplies for temperature and ten
// for the pressure polynomial in Horner form, temperature alone takes the two,
// and an item with neither reading valid takes none. One item is in work at a
// time; the input stalls until its result is loaded into the output register.
// Temperature is in 1/2^TEMP_FRAC_BITS degC, pressure in 1/2^PRESS_FRAC_BITS Pa.
// Write the calibration registers only while the block is idle.
module barometric_sensor_compensation #(
  parameter int unsigned TEMP_FRAC_BITS  = 16,
  parameter int unsigned PRESS_FRAC_BITS = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [47:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [23:0]        raw_temp_i,
  input  wire logic [23:0]        raw_press_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    temp_valid_o,
  output logic signed [23:0]      temperature_o,
  output logic                    press_valid_o,
  output logic [22:0]             pressure_o
);
  import bsc_pkg::*;

  localparam int unsigned F      = TEMP_FRAC_BITS;
  localparam int unsigned ACC_W  = 136 + 3 * F;
  localparam int unsigned SH_T2  = 18;
  localparam int unsigned SH_P11 = 3 * F;
  localparam int unsigned SH_P10 = 17 + 2 * F;
  localparam int unsigned SH_P9  = 17 + 3 * F;
  localparam int unsigned SH_P4  = 28;
  localparam int unsigned SH_P3  = 33 + F;
  localparam int unsigned SH_P2  = 36 + 2 * F;
  localparam int unsigned SH_P1  = 45 + 3 * F;
  localparam int unsigned SH_P8  = 50;
  localparam int unsigned SH_P7  = 57 + F;
  localparam int unsigned SH_P6  = 59 + 2 * F;
  localparam int unsigned SH_P5  = 68 + 3 * F;
  localparam int unsigned TSH    = 48 - F;
  localparam int unsigned PSH    = 65 + 3 * F - PRESS_FRAC_BITS;

  function automatic logic [ACC_W-1:0] coef_shift(input logic [16:0] c,
                                                   input int unsigned sh);
    logic [ACC_W-1:0] v;
    v = {{(ACC_W-17){c[16]}}, c};
    return v << sh;
  endfunction

  bsc_ctrl_t ctrl;

  logic [39:0] temp_cal_q;
  logic [47:0] sens_cal_q, offs_cal_q;
  logic [31:0] quad_cal_q;

  logic        mode_q;
  logic [23:0] raw_temp_q, raw_press_q;
  logic        tv, pv, in_fire, out_free;

  logic signed [23:0]      linear_q;
  logic signed [ACC_W-1:0] work_q, sum_q, tq, pq;
  logic [ACC_W-1:0]        addend, mcand, prod;
  logic [MUL_BITS-1:0]     mplier;
  logic                    mac_done;
  logic [ACC_W-24:0]       t_hi;
  logic [23:0]             t_sat;
  logic [22:0]             p_sat;

  logic                    out_valid_q, temp_valid_q, press_valid_q;
  logic signed [23:0]      temperature_q;
  logic [22:0]             pressure_q;

  logic [16:0] c_t2, c_t3, c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8;
  logic [16:0] c_p9, c_p10, c_p11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      sens_cal_q <= '0;
      offs_cal_q <= '0;
      quad_cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP: temp_cal_q <= cfg_data_i[39:0];
        CFG_SENS: sens_cal_q <= cfg_data_i;
        CFG_OFFS: offs_cal_q <= cfg_data_i;
        CFG_QUAD: quad_cal_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign c_t2  = {1'b0, temp_cal_q[31:16]};
  assign c_t3  = {{9{temp_cal_q[39]}}, temp_cal_q[39:32]};
  assign c_p1  = {sens_cal_q[15], sens_cal_q[15:0]} - 17'd16384;
  assign c_p2  = {sens_cal_q[31], sens_cal_q[31:16]} - 17'd16384;
  assign c_p3  = {{9{sens_cal_q[39]}}, sens_cal_q[39:32]};
  assign c_p4  = {{9{sens_cal_q[47]}}, sens_cal_q[47:40]};
  assign c_p5  = {1'b0, offs_cal_q[15:0]};
  assign c_p6  = {1'b0, offs_cal_q[31:16]};
  assign c_p7  = {{9{offs_cal_q[39]}}, offs_cal_q[39:32]};
  assign c_p8  = {{9{offs_cal_q[47]}}, offs_cal_q[47:40]};
  assign c_p9  = {quad_cal_q[15], quad_cal_q[15:0]};
  assign c_p10 = {{9{quad_cal_q[23]}}, quad_cal_q[23:16]};
  assign c_p11 = {{9{quad_cal_q[31]}}, quad_cal_q[31:24]};

  assign in_fire    = in_valid_i & ctrl.in_rdy;
  assign in_stall_o = !ctrl.in_rdy;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q      <= mode_i;
      raw_temp_q  <= raw_temp_i;
      raw_press_q <= raw_press_i;
    end
  end

  assign tv = (raw_temp_q != 24'd0);
  assign pv = mode_q & (raw_press_q != 24'd0);

  bsc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .tv_i       (tv),
    .pv_i       (pv),
    .mac_done_i (mac_done),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    case (ctrl.asel)
      AD_T3:   addend = coef_shift(c_t3, 0);
      AD_T2:   addend = coef_shift(c_t2, SH_T2);
      AD_P11:  addend = coef_shift(c_p11, SH_P11);
      AD_P10:  addend = coef_shift(c_p10, SH_P10);
      AD_P9:   addend = coef_shift(c_p9, SH_P9);
      AD_P4:   addend = coef_shift(c_p4, SH_P4);
      AD_P3:   addend = coef_shift(c_p3, SH_P3);
      AD_P2:   addend = coef_shift(c_p2, SH_P2);
      AD_P1:   addend = coef_shift(c_p1, SH_P1);
      AD_P8:   addend = coef_shift(c_p8, SH_P8);
      AD_P7:   addend = coef_shift(c_p7, SH_P7);
      AD_P6:   addend = coef_shift(c_p6, SH_P6);
      AD_P5:   addend = coef_shift(c_p5, SH_P5);
      AD_W:    addend = work_q;
      default: addend = '0;
    endcase
  end

  always_comb begin
    case (ctrl.msel)
      // raw temperature minus 256 * T1
      MSEL_D:  mplier = {1'b0, raw_temp_q} - {1'b0, temp_cal_q[15:0], 8'd0};
      MSEL_P:  mplier = {1'b0, raw_press_q};
      default: mplier = {linear_q[23], linear_q};
    endcase
  end

  assign mcand = ctrl.src_s ? sum_q : work_q;

  bsc_mac #(
    .AccW (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctrl.mac_start),
    .mcand_i  (mcand),
    .addend_i (addend),
    .mplier_i (mplier),
    .done_o   (mac_done),
    .prod_o   (prod)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      if (ctrl.dst_s) sum_q <= addend;
      else work_q <= addend;
    end else if (ctrl.write) begin
      if (ctrl.dst_s) sum_q <= prod;
      else work_q <= prod;
    end
  end

  // floor to the temperature grid, then clamp to 24 bits signed
  always_comb begin
    tq   = work_q >>> TSH;
    t_hi = tq[ACC_W-1:23];
    if ((&t_hi) || !(|t_hi)) begin
      t_sat = tq[23:0];
    end else begin
      t_sat = tq[ACC_W-1] ? 24'h800000 : 24'h7fffff;
    end
  end

  always_comb begin
    pq = sum_q >>> PSH;
    if (sum_q[ACC_W-1]) begin
      p_sat = '0;
    end else if (|pq[ACC_W-1:23]) begin
      p_sat = 23'h7fffff;
    end else begin
      p_sat = pq[22:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_q <= '0;
    end else if (ctrl.fin_t) begin
      linear_q <= t_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      temp_valid_q  <= tv;
      temperature_q <= linear_q;
      press_valid_q <= pv;
      pressure_q    <= pv ? p_sat : 23'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temp_valid_o  = temp_valid_q;
  assign temperature_o = temperature_q;
  assign press_valid_o = press_valid_q;
  assign pressure_o    = pressure_q;

endmodule

`default_nettype wire

[tb/barometric_sensor_compensation_test.sv]
`timescale 1ns / 100ps

module barometric_sensor_compensation_test;
  import bsc_pkg::*;

  localparam logic MODE_TEMP = 1'b0;
  localparam logic MODE_BOTH = 1'b1;
  localparam int unsigned PRESS_SHIFT = 113 - 6;
  localparam longint PRESS_MAX = 64'd8388607;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        tv;
    logic [23:0] temp;
    logic        pv;
    logic [22:0] press;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [23:0] raw_temp_i = '0;
  logic [23:0] raw_press_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        temp_valid_o;
  logic signed [23:0] temperature_o;
  logic        press_valid_o;
  logic [22:0] pressure_o;

  barometric_sensor_compensation u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [39:0] temp_cal;
  logic [47:0] sens_cal, offs_cal;
  logic [31:0] quad_cal;
  logic signed [23:0] kept_temp;

  reading_t pending_q[$];
  int idle_pct, stall_pct, hold_len, hold_left;
  int cycles, mismatches, readings, press_readings;

  function automatic logic signed [255:0] poly_term(longint coef, longint p, int pk,
                                                    longint lt, int lk, int sh);
    logic signed [255:0] t;
    t = coef;
    repeat (pk) t = t * p;
    repeat (lk) t = t * lt;
    return t <<< sh;
  endfunction

  function automatic reading_t compensate(logic m, logic [23:0] rt, logic [23:0] rp);
    reading_t r;
    longint d, num, q, p, lt;
    logic signed [255:0] acc;
    r.tv = (rt != 0);
    r.pv = (m == MODE_BOTH) && (rp != 0);
    if (r.tv) begin
      d = longint'(rt) - longint'(temp_cal[15:0]) * 256;
      num = d * longint'(temp_cal[31:16]) * 262144
          + d * d * longint'($signed(temp_cal[39:32]));
      q = num >>> 32;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      kept_temp = q[23:0];
    end
    r.temp = kept_temp;
    r.press = '0;
    if (r.pv) begin
      p = longint'(rp);
      lt = longint'(kept_temp);
      acc = poly_term(longint'(offs_cal[15:0]), p, 0, lt, 0, 116)
          + poly_term(longint'(offs_cal[31:16]), p, 0, lt, 1, 91)
          + poly_term(longint'($signed(offs_cal[39:32])), p, 0, lt, 2, 73)
          + poly_term(longint'($signed(offs_cal[47:40])), p, 0, lt, 3, 50)
          + poly_term(longint'($signed(sens_cal[15:0])) - 16384, p, 1, lt, 0, 93)
          + poly_term(longint'($signed(sens_cal[31:16])) - 16384, p, 1, lt, 1, 68)
          + poly_term(longint'($signed(sens_cal[39:32])), p, 1, lt, 2, 49)
          + poly_term(longint'($signed(sens_cal[47:40])), p, 1, lt, 3, 28)
          + poly_term(longint'($signed(quad_cal[15:0])), p, 2, lt, 0, 65)
          + poly_term(longint'($signed(quad_cal[23:16])), p, 2, lt, 1, 49)
          + poly_term(longint'($signed(quad_cal[31:24])), p, 3, lt, 0, 48);
      if (acc < 0) r.press = '0;
      else begin
        acc = acc >>> PRESS_SHIFT;
        r.press = (acc > PRESS_MAX) ? PRESS_MAX[22:0] : acc[22:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold when requested
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // check each accepted reading; the handshake is stable by the falling edge
  always @(negedge clk_i) begin
    reading_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading at cycle %0d", cycles);
      end else begin
        e = pending_q.pop_front();
        readings++;
        if (e.pv) press_readings++;
        if (temp_valid_o !== e.tv || temperature_o !== e.temp ||
            press_valid_o !== e.pv || pressure_o !== e.press) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tv=%0b t=%0d pv=%0b p=%0d got tv=%0b t=%0d pv=%0b p=%0d",
                     e.tv, $signed(e.temp), e.pv, e.press, temp_valid_o,
                     temperature_o, press_valid_o, pressure_o);
        end
      end
    end
  end

  task automatic write_cal(bsc_cfg_e idx, logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TEMP: temp_cal = val[39:0];
      CFG_SENS: sens_cal = val;
      CFG_OFFS: offs_cal = val;
      default:  quad_cal = val[31:0];
    endcase
  endtask

  task automatic load_cal(logic [47:0] t, logic [47:0] s, logic [47:0] o, logic [47:0] q);
    write_cal(CFG_TEMP, t);
    write_cal(CFG_SENS, s);
    write_cal(CFG_OFFS, o);
    write_cal(CFG_QUAD, q);
  endtask

  // plausible part: offsets and sensitivities near their usual values
  task automatic load_typical_cal();
    logic [15:0] p1, p2;
    p1 = 16'(16384 + $urandom_range(4000) - 2000);
    p2 = 16'(16384 + $urandom_range(4000) - 2000);
    load_cal(48'({8'($urandom), 16'($urandom_range(25000, 15000)),
                  16'($urandom_range(30000, 20000))}),
             {16'($urandom), p2, p1},
             {8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom_range(10000))},
             48'({16'($urandom), 16'($urandom)}));
  endtask

  task automatic send_item(logic m, logic [23:0] rt, logic [23:0] rp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    raw_temp_i <= rt;
    raw_press_i <= rp;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    pending_q.push_back(compensate(m, rt, rp));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [23:0] near_temp();
    longint v;
    v = longint'(temp_cal[15:0]) * 256 + longint'($urandom_range(2097152)) - 1048576;
    if (v < 1) v = 1;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[23:0];
  endfunction

  task automatic send_random();
    int k;
    logic [23:0] rt, rp;
    k = $urandom_range(99);
    rt = (k < 70) ? near_temp() : (k < 90) ? 24'($urandom) : 24'd0;
    k = $urandom_range(99);
    rp = (k < 90) ? 24'($urandom) : 24'd0;
    send_item(($urandom_range(99) < 80) ? MODE_BOTH : MODE_TEMP, rt, rp);
  endtask

  task automatic test_directed();
    // reset calibration, then the saved temperature with no valid raw reading
    send_item(MODE_BOTH, 24'd0, 24'hFFFFFF);
    send_item(MODE_TEMP, 24'd0, 24'd0);
    drain();
    load_typical_cal();
    send_item(MODE_BOTH, 24'd1, 24'd1);
    send_item(MODE_BOTH, 24'hFFFFFF, 24'hFFFFFF);
    send_item(MODE_BOTH, near_temp(), 24'h800000);
    send_item(MODE_BOTH, 24'd0, 24'h555555);
    send_item(MODE_BOTH, near_temp(), 24'd0);
    send_item(MODE_TEMP, near_temp(), 24'hAAAAAA);
    send_item(MODE_TEMP, 24'd0, 24'h123456);
    send_item(MODE_BOTH, 24'h000001, 24'h7FFFFF);
    drain();
    // all ones, also beyond each register width, then the most negative signed fields
    load_cal('1, '1, '1, '1);
    send_item(MODE_BOTH, 24'hFFFFFF, 24'hFFFFFF);
    send_item(MODE_BOTH, 24'h000001, 24'h000001);
    send_item(MODE_BOTH, 24'h800000, 24'h800000);
    drain();
    load_cal(48'({8'h80, 16'hFFFF, 16'h0000}), {8'h80, 8'h80, 16'h8000, 16'h8000},
             {8'h80, 8'h80, 16'hFFFF, 16'hFFFF}, 48'({16'h8080, 16'h8000}));
    send_item(MODE_BOTH, 24'hFFFFFF, 24'hFFFFFF);
    send_item(MODE_BOTH, 24'h000001, 24'hFFFFFF);
    send_item(MODE_BOTH, 24'h0, 24'h000001);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    if ($urandom_range(1)) load_typical_cal();
    else load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    for (int i = 0; i < n; i++) begin
      send_random();
      if (i % 60 == 59) begin
        drain();
        load_typical_cal();
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    load_typical_cal();
    hold_len = 3000;
    for (int i = 0; i < 12; i++) send_random();
    drain();
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    readings = 0;
    press_readings = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_left = 0;
    temp_cal = '0;
    sens_cal = '0;
    offs_cal = '0;
    quad_cal = '0;
    kept_temp = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(230, 0, 0);
    test_random_phase(220, 86, 0);
    test_random_phase(220, 0, 86);
    test_random_phase(230, 25, 25);
    test_backpressure();
    repeat (400) @(posedge clk_i);
    $display("%0d readings checked, %0d with pressure, over several calibrations",
             readings, press_readings);
    $display("idle and stall phases, a long output hold, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
